@@ sv/bt_pkg.sv @@
// Shared types and constants of the boundary-tag allocator.
package bt_pkg;
    localparam int ARENA_MAX_BYTES = 4096;
    localparam int ADDR_W = 12;
    localparam int SIZE_W = 13;
    localparam int HEADER_BYTES = 40;
    localparam int FOOTER_BYTES = 16;
    localparam int OVERHEAD = HEADER_BYTES + FOOTER_BYTES;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_NO_SPACE = 2'd1;
    localparam logic [1:0] ST_ZERO_SIZE = 2'd2;
    localparam logic [1:0] ST_IGNORED = 2'd3;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE = 1'b1;

    localparam logic CFG_ARENA_BYTES = 1'b0;
    localparam logic CFG_BASE_ADDRESS = 1'b1;

    typedef struct packed {
        logic              free;
        logic [SIZE_W-1:0] size;
    } t_tag;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        t_tag              wdata;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FMT,
        S_RD,
        S_CHK,
        S_AWR,
        S_NXRD,
        S_NXCHK,
        S_FWR
    } t_state;
endpackage

@@ sv/bt_tag_ram.sv @@
// Tag store: one-port-write, one-port-read memory with registered read data.
module bt_tag_ram (
    input  logic              i_clk,
    input  bt_pkg::t_mem_req  i_req,
    output bt_pkg::t_tag      o_rdata
);
    import bt_pkg::*;

    t_tag r_mem [ARENA_MAX_BYTES];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        o_rdata <= r_mem[i_req.raddr];
    end
endmodule

@@ sv/bt_ctrl.sv @@
// Sequencer that walks, splits and merges blocks through the tag store.
module bt_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic                      i_action,
    input  logic [bt_pkg::SIZE_W-1:0] i_request_size,
    input  logic [31:0]               i_block_addr,
    input  logic [bt_pkg::SIZE_W-1:0] i_arena_bytes,
    input  logic [31:0]               i_base_address,
    input  bt_pkg::t_tag              i_rdata,
    output bt_pkg::t_mem_req          o_mem,
    output logic                      o_busy,
    output logic                      o_done,
    output logic [1:0]                o_status,
    output logic [31:0]               o_address
);
    import bt_pkg::*;

    t_state              r_state, n_state;
    logic                r_action, n_action;
    logic [SIZE_W-1:0]   r_req, n_req;
    logic [31:0]         r_target, n_target;
    logic                r_ready, n_ready;
    logic [SIZE_W-1:0]   r_end, n_end;
    logic [SIZE_W-1:0]   r_cur, n_cur;
    t_tag                r_prev_tag, n_prev_tag;
    logic [SIZE_W-1:0]   r_prev, n_prev;
    logic                r_has_prev, n_has_prev;
    logic [SIZE_W-1:0]   r_start, n_start;
    logic [SIZE_W-1:0]   r_size, n_size;
    logic [SIZE_W-1:0]   r_top, n_top;
    logic [1:0]          r_wcnt, n_wcnt;
    logic                r_done, n_done;
    logic [1:0]          r_status, n_status;
    logic [31:0]         r_address, n_address;

    logic                accept;
    logic [SIZE_W-1:0]   fmt_clip, fmt_end;
    logic [SIZE_W:0]     nx_sum, need;
    logic [SIZE_W-1:0]   blk_next;
    logic                fit, hit, at_end;
    logic [SIZE_W-1:0]   rest;
    logic [SIZE_W:0]     merge_lo, merge_hi;

    assign accept   = i_start && (r_state == S_IDLE);
    assign fmt_clip = (i_arena_bytes > SIZE_W'(ARENA_MAX_BYTES))
                      ? SIZE_W'(ARENA_MAX_BYTES) : i_arena_bytes;
    assign fmt_end  = (fmt_clip < SIZE_W'(OVERHEAD)) ? '0 : fmt_clip;
    assign nx_sum   = {1'b0, r_cur} + (SIZE_W+1)'(OVERHEAD) + {1'b0, i_rdata.size};
    assign blk_next = (nx_sum > {1'b0, r_end}) ? r_end : nx_sum[SIZE_W-1:0];
    assign at_end   = (blk_next >= r_end);
    assign need     = (SIZE_W+1)'(OVERHEAD) + {1'b0, r_req};
    assign fit      = i_rdata.free && ({1'b0, i_rdata.size} >= need);
    assign hit      = ({{(32-SIZE_W){1'b0}}, r_cur} == r_target);
    assign rest     = SIZE_W'({1'b0, i_rdata.size} - need);
    assign merge_lo = {1'b0, i_rdata.size} + {1'b0, r_prev_tag.size}
                      + (SIZE_W+1)'(OVERHEAD);
    assign merge_hi = {1'b0, r_size} + {1'b0, i_rdata.size} + (SIZE_W+1)'(OVERHEAD);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_action == ACT_ALLOC) begin
                        if (i_request_size == '0) begin
                            n_state = S_IDLE;
                        end else if (!r_ready) begin
                            n_state = (fmt_end != '0) ? S_FMT : S_IDLE;
                        end else begin
                            n_state = (r_end != '0) ? S_RD : S_IDLE;
                        end
                    end else begin
                        n_state = (r_ready && r_end != '0) ? S_RD : S_IDLE;
                    end
                end
            end
            S_FMT: n_state = (r_wcnt == 2'd1) ? S_RD : S_FMT;
            S_RD: n_state = S_CHK;
            S_CHK: begin
                if (r_action == ACT_ALLOC) begin
                    if (fit) begin
                        n_state = S_AWR;
                    end else begin
                        n_state = at_end ? S_IDLE : S_RD;
                    end
                end else if (hit) begin
                    if (i_rdata.free) begin
                        n_state = S_IDLE;
                    end else begin
                        n_state = at_end ? S_FWR : S_NXRD;
                    end
                end else begin
                    n_state = at_end ? S_IDLE : S_RD;
                end
            end
            S_AWR: n_state = (r_wcnt == 2'd3) ? S_IDLE : S_AWR;
            S_NXRD: n_state = S_NXCHK;
            S_NXCHK: n_state = S_FWR;
            S_FWR: n_state = (r_wcnt == 2'd1) ? S_IDLE : S_FWR;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_action   = r_action;
        n_req      = r_req;
        n_target   = r_target;
        n_ready    = r_ready;
        n_end      = r_end;
        n_cur      = r_cur;
        n_prev_tag = r_prev_tag;
        n_prev     = r_prev;
        n_has_prev = r_has_prev;
        n_start    = r_start;
        n_size     = r_size;
        n_top      = r_top;
        n_wcnt     = '0;
        n_done     = 1'b0;
        n_status   = r_status;
        n_address  = r_address;
        o_mem      = '0;
        o_mem.raddr = r_cur[ADDR_W-1:0];
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_action   = i_action;
                    n_req      = i_request_size;
                    n_target   = i_block_addr - i_base_address - 32'(HEADER_BYTES);
                    n_cur      = '0;
                    n_has_prev = 1'b0;
                    n_address  = '0;
                    if (i_action == ACT_ALLOC) begin
                        if (i_request_size == '0) begin
                            n_done   = 1'b1;
                            n_status = ST_ZERO_SIZE;
                        end else if (!r_ready) begin
                            n_ready = 1'b1;
                            n_end   = fmt_end;
                            if (fmt_end == '0) begin
                                n_done   = 1'b1;
                                n_status = ST_NO_SPACE;
                            end
                        end else if (r_end == '0) begin
                            n_done   = 1'b1;
                            n_status = ST_NO_SPACE;
                        end
                    end else if (!r_ready || r_end == '0) begin
                        n_done   = 1'b1;
                        n_status = ST_IGNORED;
                    end
                end
            end
            S_FMT: begin
                o_mem.we = 1'b1;
                o_mem.wdata.free = 1'b1;
                o_mem.wdata.size = r_end - SIZE_W'(OVERHEAD);
                o_mem.waddr = (r_wcnt == 2'd0) ? '0
                              : ADDR_W'(r_end - SIZE_W'(FOOTER_BYTES));
                n_wcnt = r_wcnt + 2'd1;
            end
            S_RD: begin
            end
            S_CHK: begin
                if (r_action == ACT_ALLOC) begin
                    if (fit) begin
                        n_size = rest;
                        n_top  = SIZE_W'({1'b0, r_cur} + (SIZE_W+1)'(OVERHEAD)
                                 + {1'b0, rest});
                    end else begin
                        n_cur = blk_next;
                        if (at_end) begin
                            n_done   = 1'b1;
                            n_status = ST_NO_SPACE;
                        end
                    end
                end else if (hit) begin
                    if (i_rdata.free) begin
                        n_done   = 1'b1;
                        n_status = ST_IGNORED;
                    end else begin
                        n_cur = blk_next;
                        if (r_has_prev && r_prev_tag.free) begin
                            n_start = r_prev;
                            n_size  = merge_lo[SIZE_W-1:0];
                        end else begin
                            n_start = r_cur;
                            n_size  = i_rdata.size;
                        end
                    end
                end else begin
                    n_prev     = r_cur;
                    n_prev_tag = i_rdata;
                    n_has_prev = 1'b1;
                    n_cur      = blk_next;
                    if (at_end) begin
                        n_done   = 1'b1;
                        n_status = ST_IGNORED;
                    end
                end
            end
            S_AWR: begin
                o_mem.we = 1'b1;
                n_wcnt = r_wcnt + 2'd1;
                unique case (r_wcnt)
                    2'd0: begin
                        o_mem.waddr = r_cur[ADDR_W-1:0];
                        o_mem.wdata = '{free: 1'b1, size: r_size};
                    end
                    2'd1: begin
                        o_mem.waddr = ADDR_W'(r_cur + SIZE_W'(HEADER_BYTES) + r_size);
                        o_mem.wdata = '{free: 1'b1, size: r_size};
                    end
                    2'd2: begin
                        o_mem.waddr = r_top[ADDR_W-1:0];
                        o_mem.wdata = '{free: 1'b0, size: r_req};
                    end
                    default: begin
                        o_mem.waddr = ADDR_W'(r_top + SIZE_W'(HEADER_BYTES) + r_req);
                        o_mem.wdata = '{free: 1'b0, size: r_req};
                        n_done    = 1'b1;
                        n_status  = ST_OK;
                        n_address = i_base_address + 32'(r_top) + 32'(HEADER_BYTES);
                    end
                endcase
            end
            S_NXRD: begin
            end
            S_NXCHK: begin
                if (i_rdata.free) begin
                    n_size = merge_hi[SIZE_W-1:0];
                end
            end
            S_FWR: begin
                o_mem.we = 1'b1;
                o_mem.wdata = '{free: 1'b1, size: r_size};
                o_mem.waddr = (r_wcnt == 2'd0) ? r_start[ADDR_W-1:0]
                              : ADDR_W'(r_start + SIZE_W'(HEADER_BYTES) + r_size);
                n_wcnt = r_wcnt + 2'd1;
                if (r_wcnt == 2'd1) begin
                    n_done   = 1'b1;
                    n_status = ST_OK;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ready   <= 1'b0;
            r_end     <= '0;
            r_wcnt    <= '0;
            r_done    <= 1'b0;
            r_status  <= ST_OK;
            r_address <= '0;
        end else begin
            r_state   <= n_state;
            r_ready   <= n_ready;
            r_end     <= n_end;
            r_wcnt    <= n_wcnt;
            r_done    <= n_done;
            r_status  <= n_status;
            r_address <= n_address;
        end
    end

    always_ff @(posedge i_clk) begin
        r_action   <= n_action;
        r_req      <= n_req;
        r_target   <= n_target;
        r_cur      <= n_cur;
        r_prev_tag <= n_prev_tag;
        r_prev     <= n_prev;
        r_has_prev <= n_has_prev;
        r_start    <= n_start;
        r_size     <= n_size;
        r_top      <= n_top;
    end

    assign o_busy    = (r_state != S_IDLE);
    assign o_done    = r_done;
    assign o_status  = r_status;
    assign o_address = r_address;

`ifndef ASSERT_OFF
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> r_state == S_IDLE)
        else $error("word delivered while the sequencer is still busy");
    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> !o_mem.we)
        else $error("tag write while idle");
    a_accept_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_busy || r_done)
        else $error("accepted word neither started nor answered");
    a_addr_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done && r_status != ST_OK |-> r_address == '0)
        else $error("nonzero address on a failed request");
`endif
endmodule

@@ sv/boundary_tag_first_fit_allocator.sv @@
// Top level of the boundary-tag first-fit allocator: configuration and tag store.
// An allocate reads and checks each block, the fitting one included, then writes two tag pairs;
// a free reads and checks each block up to and including the target, then the next one if any,
// and writes the freed block's header and footer. A first nonzero allocate formats the arena.
// One word at a time, paced by the single read port of the tag store. The result strobe lasts
// one cycle in the first cycle with busy low, and the receiver cannot stall it.
// Synchronous active-low reset idles control, arena 4096 bytes, base 0; tag store not cleared.
module boundary_tag_first_fit_allocator (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    output logic                      o_busy,
    input  logic                      i_action,
    input  logic [bt_pkg::SIZE_W-1:0] i_request_size,
    input  logic [31:0]               i_block_addr,
    output logic                      o_done,
    output logic [1:0]                o_status,
    output logic [31:0]               o_address,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_index,
    input  logic [31:0]               i_cfg_data
);
    import bt_pkg::*;

    logic [SIZE_W-1:0] r_arena_bytes;
    logic [31:0]       r_base_address;
    t_mem_req          mem_req;
    t_tag              mem_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arena_bytes  <= SIZE_W'(ARENA_MAX_BYTES);
            r_base_address <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_ARENA_BYTES) begin
                r_arena_bytes <= i_cfg_data[SIZE_W-1:0];
            end else begin
                r_base_address <= i_cfg_data;
            end
        end
    end

    bt_tag_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    bt_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .i_action       (i_action),
        .i_request_size (i_request_size),
        .i_block_addr   (i_block_addr),
        .i_arena_bytes  (r_arena_bytes),
        .i_base_address (r_base_address),
        .i_rdata        (mem_rdata),
        .o_mem          (mem_req),
        .o_busy         (o_busy),
        .o_done         (o_done),
        .o_status       (o_status),
        .o_address      (o_address)
    );
endmodule
